/* rtl/tmp_pkg.sv */
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types, widths and command codes of the trapezoid motion profile.
// ----------------------------------------------------------------------------
package tmp_pkg;

   localparam int TMP_AXES_DEF      = 4;
   localparam int TMP_POS_SCALE_DEF = 8;

   localparam int TMP_OP_W    = 2;
   localparam int TMP_AXIS_W  = 2;
   localparam int TMP_CNT_W   = 32;   // target, measured and output positions
   localparam int TMP_SPEED_W = 24;
   localparam int TMP_RATE_W  = 16;
   localparam int TMP_POS_W   = 48;
   localparam int TMP_VEL_W   = 40;
   localparam int TMP_STEP_W  = 32;

   localparam logic [TMP_OP_W-1:0] TMP_OP_TICK     = 2'd0;
   localparam logic [TMP_OP_W-1:0] TMP_OP_MOVE     = 2'd1;
   localparam logic [TMP_OP_W-1:0] TMP_OP_VELOCITY = 2'd2;
   localparam logic [TMP_OP_W-1:0] TMP_OP_STOP     = 2'd3;

   // One axis worth of trajectory state, as held in the state memory
   typedef struct packed {
      logic signed [TMP_POS_W-1:0]  gen_pos;
      logic signed [TMP_VEL_W-1:0]  gen_vel;
      logic signed [TMP_STEP_W-1:0] step_vel;
      logic signed [TMP_POS_W-1:0]  end_pos;
      logic signed [TMP_VEL_W-1:0]  cruise_vel;
      logic        [TMP_RATE_W-1:0] ramp;
      logic signed [TMP_POS_W-1:0]  budget;
      logic signed [TMP_CNT_W-1:0]  out_pos;
   } tmp_entry_type;

   localparam int TMP_ENTRY_W = $bits(tmp_entry_type);

   typedef struct packed {
      logic pos_on;      // position move running on the axis
      logic load;        // capture entry, form distance
      logic vel_step;    // decide deceleration, form ramp candidates
      logic clamp_step;  // pick new velocity and step
   } tmp_adv_ctrl_type;

   typedef struct packed {
      logic finish;
      logic vel_zero;
      logic cruise_zero;
   } tmp_adv_stat_type;

endpackage

/* rtl/tmp_ram.sv */
// ----------------------------------------------------------------------------
// tmp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tmp_ram #(
   parameter int WIDTH = tmp_pkg::TMP_ENTRY_W,
   parameter int DEPTH = tmp_pkg::TMP_AXES_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tmp_advance.sv */
// ----------------------------------------------------------------------------
// tmp_advance
// Three-step datapath that moves one axis entry forward by one tick.
// ----------------------------------------------------------------------------
module tmp_advance #(
   parameter int POS_SCALE = tmp_pkg::TMP_POS_SCALE_DEF
) (
   input  logic                      clock,
   input  tmp_pkg::tmp_adv_ctrl_type ctrl,
   input  tmp_pkg::tmp_entry_type    entry_in,
   output tmp_pkg::tmp_entry_type    entry_cur,
   output tmp_pkg::tmp_entry_type    entry_upd,
   output tmp_pkg::tmp_adv_stat_type stat
);
   import tmp_pkg::*;

   tmp_entry_type                ent_ff;
   logic signed [TMP_POS_W-1:0]  dist_ff;
   logic                         gen_ge_ff, gen_le_ff, pos_on_ff;
   logic                         dec_ff, gv_pos_ff, big_pos_ff, big_neg_ff;
   logic                         below_ff, above_ff;
   logic signed [TMP_VEL_W-1:0]  vel_up_ff, vel_dn_ff, vel_new_ff;
   logic signed [TMP_STEP_W-1:0] step_new_ff;
   logic                         finish_ff;

   logic signed [TMP_POS_W-1:0]  rem;
   logic signed [TMP_VEL_W-1:0]  gv, rate, rate2;
   logic                         gv_pos, gv_neg, dec_in;
   logic signed [TMP_VEL_W-1:0]  vel_sel, vel_shift;
   logic signed [TMP_STEP_W-1:0] step_sel;
   logic                         finish_in;
   logic signed [TMP_POS_W-1:0]  step_ext, step_old_ext, budget_new, gen_new, gen_shift;

   // distance left after the stopping budget
   assign rem    = dist_ff - ent_ff.budget;
   assign gv     = ent_ff.gen_vel;
   assign rate   = $signed({{(TMP_VEL_W-TMP_RATE_W){1'b0}}, ent_ff.ramp});
   assign rate2  = rate <<< 1;
   assign gv_pos = !gv[TMP_VEL_W-1] && (gv != '0);
   assign gv_neg = gv[TMP_VEL_W-1];
   assign dec_in = pos_on_ff &&
                   ((gv_pos && (rem[TMP_POS_W-1] || rem == '0)) ||
                    (gv_neg && !rem[TMP_POS_W-1]));

   always_comb begin
      priority if (dec_ff) begin
         if (gv_pos_ff) begin
            vel_sel = big_pos_ff ? vel_dn_ff : gv;
         end else begin
            vel_sel = big_neg_ff ? vel_up_ff : gv;
         end
      end else if (below_ff) begin
         vel_sel = (vel_up_ff > ent_ff.cruise_vel) ? ent_ff.cruise_vel : vel_up_ff;
      end else if (above_ff) begin
         vel_sel = (vel_dn_ff < ent_ff.cruise_vel) ? ent_ff.cruise_vel : vel_dn_ff;
      end else begin
         vel_sel = gv;
      end
   end

   assign vel_shift = vel_sel >>> POS_SCALE;
   assign step_sel  = (dec_ff || below_ff || above_ff) ? vel_shift[TMP_STEP_W-1:0]
                                                       : ent_ff.step_vel;
   assign finish_in = dec_ff && (gv_pos_ff ? gen_ge_ff : gen_le_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         ent_ff    <= entry_in;
         dist_ff   <= entry_in.end_pos - entry_in.gen_pos;
         gen_ge_ff <= entry_in.gen_pos >= entry_in.end_pos;
         gen_le_ff <= entry_in.gen_pos <= entry_in.end_pos;
         pos_on_ff <= ctrl.pos_on;
      end
      if (ctrl.vel_step) begin
         dec_ff     <= dec_in;
         gv_pos_ff  <= gv_pos;
         big_pos_ff <= gv >= rate2;
         big_neg_ff <= gv <= -rate2;
         below_ff   <= gv < ent_ff.cruise_vel;
         above_ff   <= gv > ent_ff.cruise_vel;
         vel_up_ff  <= gv + rate;
         vel_dn_ff  <= gv - rate;
      end
      if (ctrl.clamp_step) begin
         vel_new_ff  <= vel_sel;
         step_new_ff <= step_sel;
         finish_ff   <= finish_in;
      end
   end

   assign step_ext     = {{(TMP_POS_W-TMP_STEP_W){step_new_ff[TMP_STEP_W-1]}}, step_new_ff};
   assign step_old_ext = {{(TMP_POS_W-TMP_STEP_W){ent_ff.step_vel[TMP_STEP_W-1]}},
                          ent_ff.step_vel};

   // decelerating spends the new step, ramping banks the old one
   always_comb begin
      priority if (dec_ff) begin
         budget_new = ent_ff.budget - step_ext;
      end else if (below_ff || above_ff) begin
         budget_new = ent_ff.budget + step_old_ext;
      end else begin
         budget_new = ent_ff.budget;
      end
   end

   assign gen_new   = finish_ff ? ent_ff.end_pos : ent_ff.gen_pos + step_ext;
   assign gen_shift = gen_new >>> POS_SCALE;

   always_comb begin
      entry_upd          = ent_ff;
      entry_upd.gen_pos  = gen_new;
      entry_upd.gen_vel  = vel_new_ff;
      entry_upd.step_vel = step_new_ff;
      entry_upd.budget   = budget_new;
      entry_upd.out_pos  = gen_shift[TMP_CNT_W-1:0];
   end

   assign entry_cur        = ent_ff;
   assign stat.finish      = finish_ff;
   assign stat.vel_zero    = (vel_new_ff == '0);
   assign stat.cruise_zero = (ent_ff.cruise_vel == '0);

endmodule

/* rtl/trapezoid_motion_profile.sv */
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Multi-axis trapezoidal set-point generator with per-axis state in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge with start high and busy low. Ops:
//   tick, position move, velocity move, stop axis. A tick returns one
//   result per axis, axis 0 first, each on the rsp_ ports for exactly one
//   cycle with rsp_strobe high; rsp_last marks the highest axis.
//   Per axis the sequencer reads the state RAM, then either writes back an
//   advanced entry (read, distance, ramp, clamp, write steps for an axis
//   with a move running) or just reports it (read, distance, write for an
//   idle axis). A result shows up the cycle after its write step. A tick
//   keeps busy high until the last axis is reported, as all axes share the
//   one RAM port pair and the three-step update datapath and go one by one.
//   A move or velocity request keeps busy high for a read and a merge-write.
//   Stops, ignored moves and requests for a missing axis finish on the
//   accepting edge; busy stays low.
//   Reset clears the move bits and the RAM valid bits; an unwritten entry
//   reads as zero, so no clearing pass runs. The receiver cannot stall:
//   results are never held.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile #(
   parameter int AXES      = tmp_pkg::TMP_AXES_DEF,
   parameter int POS_SCALE = tmp_pkg::TMP_POS_SCALE_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic        [tmp_pkg::TMP_OP_W-1:0]    req_op,
   input  logic        [tmp_pkg::TMP_AXIS_W-1:0]  req_axis,
   input  logic signed [tmp_pkg::TMP_CNT_W-1:0]   req_target_position,
   input  logic signed [tmp_pkg::TMP_SPEED_W-1:0] req_speed,
   input  logic        [tmp_pkg::TMP_RATE_W-1:0]  req_accel,
   input  logic                                   req_absolute,
   input  logic signed [tmp_pkg::TMP_CNT_W-1:0]   req_measured_position,
   input  logic                                   req_servo_idle,
   output logic                                   rsp_strobe,
   output logic        [tmp_pkg::TMP_AXIS_W-1:0]  rsp_out_axis,
   output logic signed [tmp_pkg::TMP_CNT_W-1:0]   rsp_set_position,
   output logic                                   rsp_active,
   output logic                                   rsp_last
);
   import tmp_pkg::*;

   localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
   localparam logic [AW-1:0] LAST_AXIS = AW'(AXES - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_DIFF  = 3'd2;
   localparam logic [2:0] ST_VEL   = 3'd3;
   localparam logic [2:0] ST_CLAMP = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_CMD   = 3'd6;

   logic [2:0]      state_ff, state_in;
   logic [AW-1:0]   axis_ff, axis_in;
   logic [AXES-1:0] pos_on_ff, pos_on_in, vel_on_ff, vel_on_in, vld_ff, vld_in;
   logic            act_ff, act_in;
   logic            rsp_strobe_ff, rsp_strobe_in;
   logic            rsp_active_in, rsp_last_in;
   logic            rsp_active_ff, rsp_last_ff;
   logic [TMP_AXIS_W-1:0]       rsp_axis_ff, rsp_axis_in;
   logic signed [TMP_CNT_W-1:0] rsp_pos_ff, rsp_pos_in;

   // request payload
   logic [TMP_OP_W-1:0]          op_ff;
   logic                         done_ff, abs_ff;
   logic signed [TMP_CNT_W-1:0]  target_ff, meas_ff;
   logic signed [TMP_SPEED_W-1:0] speed_ff;
   logic [TMP_RATE_W-1:0]        accel_ff;

   // command operands prepared while the RAM read is in flight
   logic signed [TMP_POS_W-1:0] cmd_gen_ff, cmd_end_ff;
   logic signed [TMP_VEL_W-1:0] cmd_up_ff, cmd_dn_ff, cmd_spd_ff;

   logic                         accept, in_range, req_done;
   logic [AW-1:0]                req_idx;
   logic signed [TMP_CNT_W-1:0]  end_cnt;
   logic signed [TMP_POS_W-1:0]  meas_ext, end_ext;
   logic signed [TMP_SPEED_W:0]  speed_ext, speed_mag;
   logic signed [TMP_VEL_W-1:0]  mag_ext, spd_ext, mag_sh;

   logic                         ram_we, ram_re;
   logic [TMP_ENTRY_W-1:0]       ram_rd, ram_wd;
   tmp_entry_type                rd_entry, ent_cmd;
   tmp_entry_type                adv_cur, adv_upd;
   tmp_adv_ctrl_type             adv_ctrl;
   tmp_adv_stat_type             adv_stat;
   logic                         pos_keep, vel_keep;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = ({{(32-TMP_AXIS_W){1'b0}}, req_axis} < 32'(AXES));
   assign req_idx  = AW'(req_axis);
   assign req_done = !pos_on_ff[req_idx] && req_servo_idle;

   tmp_ram #(
      .WIDTH (TMP_ENTRY_W),
      .DEPTH (AXES),
      .AW    (AW)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (axis_ff),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (axis_ff),
      .rd_data (ram_rd)
   );

   tmp_advance #(
      .POS_SCALE (POS_SCALE)
   ) u_advance (
      .clock     (clock),
      .ctrl      (adv_ctrl),
      .entry_in  (rd_entry),
      .entry_cur (adv_cur),
      .entry_upd (adv_upd),
      .stat      (adv_stat)
   );

   // an entry never written reads as all zero
   assign rd_entry = vld_ff[axis_ff] ? tmp_entry_type'(ram_rd) : '0;

   // command operands
   assign end_cnt   = abs_ff ? target_ff : target_ff + meas_ff;
   assign meas_ext  = {{(TMP_POS_W-TMP_CNT_W){meas_ff[TMP_CNT_W-1]}}, meas_ff};
   assign end_ext   = {{(TMP_POS_W-TMP_CNT_W){end_cnt[TMP_CNT_W-1]}}, end_cnt};
   assign speed_ext = {speed_ff[TMP_SPEED_W-1], speed_ff};
   assign speed_mag = speed_ext[TMP_SPEED_W] ? -speed_ext : speed_ext;
   assign mag_ext   = {{(TMP_VEL_W-TMP_SPEED_W-1){1'b0}}, speed_mag};
   assign spd_ext   = {{(TMP_VEL_W-TMP_SPEED_W){speed_ff[TMP_SPEED_W-1]}}, speed_ff};
   assign mag_sh    = mag_ext <<< POS_SCALE;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         done_ff   <= req_done;
         abs_ff    <= req_absolute;
         target_ff <= req_target_position;
         meas_ff   <= req_measured_position;
         speed_ff  <= req_speed;
         accel_ff  <= req_accel;
      end
      if (state_ff == ST_READ) begin
         cmd_gen_ff <= meas_ext <<< POS_SCALE;
         cmd_end_ff <= end_ext <<< POS_SCALE;
         cmd_up_ff  <= mag_sh;
         cmd_dn_ff  <= -mag_sh;
         cmd_spd_ff <= spd_ext <<< POS_SCALE;
      end
   end

   // merge a move or velocity request into the stored entry
   always_comb begin
      ent_cmd = rd_entry;
      if (op_ff == TMP_OP_MOVE) begin
         ent_cmd.gen_pos    = cmd_gen_ff;
         ent_cmd.end_pos    = cmd_end_ff;
         ent_cmd.cruise_vel = (cmd_end_ff > cmd_gen_ff) ? cmd_up_ff : cmd_dn_ff;
         ent_cmd.ramp       = accel_ff;
         ent_cmd.gen_vel    = '0;
         ent_cmd.step_vel   = '0;
         ent_cmd.budget     = '0;
      end else begin
         if (done_ff) begin
            ent_cmd.gen_pos  = cmd_gen_ff;
            ent_cmd.gen_vel  = '0;
            ent_cmd.step_vel = '0;
         end
         ent_cmd.cruise_vel = cmd_spd_ff;
         ent_cmd.ramp       = accel_ff;
      end
   end

   assign pos_keep = pos_on_ff[axis_ff] && !adv_stat.finish;
   assign vel_keep = vel_on_ff[axis_ff] && !(adv_stat.cruise_zero && adv_stat.vel_zero);

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      pos_on_in     = pos_on_ff;
      vel_on_in     = vel_on_ff;
      vld_in        = vld_ff;
      act_in        = act_ff;
      ram_re        = 1'b0;
      ram_we        = 1'b0;
      ram_wd        = ent_cmd;
      adv_ctrl      = '0;
      adv_ctrl.pos_on = pos_on_ff[axis_ff];
      rsp_strobe_in = 1'b0;
      rsp_axis_in   = rsp_axis_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_active_in = rsp_active_ff;
      // drop the last flag once its result cycle is over
      rsp_last_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_op == TMP_OP_TICK) begin
                  axis_in  = '0;
                  state_in = ST_READ;
               end else if (!in_range) begin
                  state_in = ST_IDLE;
               end else if (req_op == TMP_OP_STOP) begin
                  pos_on_in[req_idx] = 1'b0;
                  vel_on_in[req_idx] = 1'b0;
               end else if (req_op == TMP_OP_MOVE && !req_done) begin
                  state_in = ST_IDLE;
               end else begin
                  axis_in  = req_idx;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = (op_ff == TMP_OP_TICK) ? ST_DIFF : ST_CMD;
         end
         ST_DIFF: begin
            adv_ctrl.load = 1'b1;
            act_in   = pos_on_ff[axis_ff] || vel_on_ff[axis_ff];
            state_in = (pos_on_ff[axis_ff] || vel_on_ff[axis_ff]) ? ST_VEL : ST_WRITE;
         end
         ST_VEL: begin
            adv_ctrl.vel_step = 1'b1;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            adv_ctrl.clamp_step = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            rsp_strobe_in = 1'b1;
            rsp_axis_in   = TMP_AXIS_W'(axis_ff);
            rsp_last_in   = (axis_ff == LAST_AXIS);
            if (act_ff) begin
               ram_we             = 1'b1;
               ram_wd             = adv_upd;
               vld_in[axis_ff]    = 1'b1;
               pos_on_in[axis_ff] = pos_keep;
               vel_on_in[axis_ff] = vel_keep;
               rsp_pos_in         = adv_upd.out_pos;
               rsp_active_in      = pos_keep || vel_keep;
            end else begin
               rsp_pos_in    = adv_cur.out_pos;
               rsp_active_in = 1'b0;
            end
            if (axis_ff == LAST_AXIS) begin
               state_in = ST_IDLE;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_CMD: begin
            ram_we          = 1'b1;
            vld_in[axis_ff] = 1'b1;
            if (op_ff == TMP_OP_MOVE) begin
               pos_on_in[axis_ff] = 1'b1;
               vel_on_in[axis_ff] = 1'b0;
            end else begin
               pos_on_in[axis_ff] = 1'b0;
               vel_on_in[axis_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         axis_ff       <= '0;
         pos_on_ff     <= '0;
         vel_on_ff     <= '0;
         vld_ff        <= '0;
         act_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         pos_on_ff     <= pos_on_in;
         vel_on_ff     <= vel_on_in;
         vld_ff        <= vld_in;
         act_ff        <= act_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_axis_ff   <= rsp_axis_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_active_ff <= rsp_active_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_axis     = rsp_axis_ff;
   assign rsp_set_position = rsp_pos_ff;
   assign rsp_active       = rsp_active_ff;
   assign rsp_last         = rsp_last_ff;

   a_strobe_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_WRITE)
      else $error("result strobe without a write step");

   a_ram_one_access: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ram_re)
      else $error("state RAM read and write in the same cycle");

   a_move_kinds_exclusive: assert property (@(posedge clock) disable iff (reset)
      (pos_on_ff & vel_on_ff) == '0)
      else $error("position and velocity move both running on one axis");

   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("last flag without result strobe");

   a_tick_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == TMP_OP_TICK) |=> busy)
      else $error("tick request did not start the axis sweep");

endmodule

/* tb/trapezoid_motion_profile_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_motion_profile_tb
// Self-checking bench: drives tick, position move, velocity move and stop
// requests with random gaps, predicts every axis set-point in a scoreboard
// and compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile_tb;
   import tmp_pkg::*;

   localparam int AXES         = TMP_AXES_DEF;
   localparam int POS_SCALE    = TMP_POS_SCALE_DEF;
   localparam int DIRECTED     = 25;
   localparam int RANDOM_ITEMS = 305;
   localparam int QUIET_LIMIT  = 400;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [TMP_OP_W-1:0]           op;
      logic [TMP_AXIS_W-1:0]         axis;
      logic signed [TMP_CNT_W-1:0]   target;
      logic signed [TMP_SPEED_W-1:0] speed;
      logic [TMP_RATE_W-1:0]         accel;
      logic                          absolute;
      logic signed [TMP_CNT_W-1:0]   measured;
      logic                          servo_idle;
   } motion_cmd_t;

   typedef struct packed {
      logic [TMP_AXIS_W-1:0]       axis;
      logic signed [TMP_CNT_W-1:0] position;
      logic                        active;
      logic                        last;
   } setpoint_t;

   class profile_scoreboard;
      bit [AXES-1:0] pos_on;
      bit [AXES-1:0] vel_on;
      longint gen_pos[AXES];
      longint gen_vel[AXES];
      longint step_vel[AXES];
      longint end_pos[AXES];
      longint cruise[AXES];
      longint ramp[AXES];
      longint budget[AXES];
      longint out_pos[AXES];
      setpoint_t setpoint_q[$];
      int errors;

      function new();
         pos_on = '0;
         vel_on = '0;
         errors = 0;
         for (int a = 0; a < AXES; a++) begin
            gen_pos[a]  = 0;
            gen_vel[a]  = 0;
            step_vel[a] = 0;
            end_pos[a]  = 0;
            cruise[a]   = 0;
            ramp[a]     = 0;
            budget[a]   = 0;
            out_pos[a]  = 0;
         end
      endfunction

      // sign-extend the low w bits
      static function longint wrap(longint v, int w);
         return (v <<< (64 - w)) >>> (64 - w);
      endfunction

      function int pending();
         return setpoint_q.size();
      endfunction

      function void advance(int a);
         bit decel;
         bit arrive;
         longint gv;
         longint rate;
         longint remain;
         decel  = 0;
         arrive = 0;
         gv     = gen_vel[a];
         rate   = ramp[a];
         if (pos_on[a]) begin
            remain = wrap(wrap(end_pos[a] - gen_pos[a], TMP_POS_W) - budget[a], TMP_POS_W);
            if (gv > 0)
               decel = (remain <= 0);
            else if (gv < 0)
               decel = (remain >= 0);
         end
         if (decel) begin
            // stop slowing once the speed is below twice the ramp rate
            if (gv > 0) begin
               if (gv >= 2 * rate)
                  gv = wrap(gv - rate, TMP_VEL_W);
               arrive = (gen_pos[a] >= end_pos[a]);
            end else begin
               if (gv <= -2 * rate)
                  gv = wrap(gv + rate, TMP_VEL_W);
               arrive = (gen_pos[a] <= end_pos[a]);
            end
            step_vel[a] = wrap(gv >>> POS_SCALE, TMP_STEP_W);
            budget[a]   = wrap(budget[a] - step_vel[a], TMP_POS_W);
         end else if (gv < cruise[a]) begin
            budget[a] = wrap(budget[a] + step_vel[a], TMP_POS_W);
            gv = wrap(gv + rate, TMP_VEL_W);
            if (gv > cruise[a])
               gv = cruise[a];
            step_vel[a] = wrap(gv >>> POS_SCALE, TMP_STEP_W);
         end else if (gv > cruise[a]) begin
            budget[a] = wrap(budget[a] + step_vel[a], TMP_POS_W);
            gv = wrap(gv - rate, TMP_VEL_W);
            if (gv < cruise[a])
               gv = cruise[a];
            step_vel[a] = wrap(gv >>> POS_SCALE, TMP_STEP_W);
         end
         gen_vel[a] = gv;
         if (vel_on[a] && cruise[a] == 0 && gv == 0)
            vel_on[a] = 0;
         if (arrive) begin
            gen_pos[a] = end_pos[a];
            pos_on[a]  = 0;
         end else begin
            gen_pos[a] = wrap(gen_pos[a] + step_vel[a], TMP_POS_W);
         end
         out_pos[a] = wrap(gen_pos[a] >>> POS_SCALE, TMP_CNT_W);
      endfunction

      function void note(motion_cmd_t r);
         setpoint_t sp;
         int a;
         bit settled;
         longint meas;
         longint tgt;
         longint spd;
         longint mag;
         longint dest;
         meas = r.measured;
         tgt  = r.target;
         spd  = r.speed;
         if (r.op == TMP_OP_TICK) begin
            for (int k = 0; k < AXES; k++) begin
               if (pos_on[k] | vel_on[k])
                  advance(k);
               sp.axis     = TMP_AXIS_W'(k);
               sp.position = TMP_CNT_W'(out_pos[k]);
               sp.active   = pos_on[k] | vel_on[k];
               sp.last     = (k == AXES - 1);
               setpoint_q.push_back(sp);
            end
            return;
         end
         a = r.axis;
         if (a >= AXES)
            return;
         settled = !pos_on[a] && r.servo_idle;
         case (r.op)
            TMP_OP_MOVE: begin
               if (!settled)
                  return;
               mag        = (spd < 0) ? -spd : spd;
               gen_pos[a] = wrap(meas <<< POS_SCALE, TMP_POS_W);
               dest       = r.absolute ? tgt : wrap(tgt + meas, TMP_CNT_W);
               end_pos[a] = wrap(dest <<< POS_SCALE, TMP_POS_W);
               if (end_pos[a] > gen_pos[a])
                  cruise[a] = wrap(mag <<< POS_SCALE, TMP_VEL_W);
               else
                  cruise[a] = wrap(-(mag <<< POS_SCALE), TMP_VEL_W);
               ramp[a]     = r.accel;
               gen_vel[a]  = 0;
               step_vel[a] = 0;
               budget[a]   = 0;
               pos_on[a]   = 1;
               vel_on[a]   = 0;
            end
            TMP_OP_VELOCITY: begin
               // sync to the servo only when the axis is at rest
               if (settled) begin
                  gen_pos[a]  = wrap(meas <<< POS_SCALE, TMP_POS_W);
                  gen_vel[a]  = 0;
                  step_vel[a] = 0;
               end
               cruise[a] = wrap(spd <<< POS_SCALE, TMP_VEL_W);
               ramp[a]   = r.accel;
               vel_on[a] = 1;
               pos_on[a] = 0;
            end
            TMP_OP_STOP: begin
               pos_on[a] = 0;
               vel_on[a] = 0;
            end
            default: ;
         endcase
      endfunction

      function void check(setpoint_t got);
         setpoint_t want;
         if (setpoint_q.size() == 0) begin
            $error("unexpected set-point on axis %0d", got.axis);
            errors++;
            return;
         end
         want = setpoint_q.pop_front();
         if (got.axis !== want.axis) begin
            $error("out_axis: expected %0d, got %0d", want.axis, got.axis);
            errors++;
         end
         if (got.position !== want.position) begin
            $error("set_position: expected %0d, got %0d", want.position, got.position);
            errors++;
         end
         if (got.active !== want.active) begin
            $error("active: expected %0d, got %0d", want.active, got.active);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [TMP_OP_W-1:0]           req_op;
   logic [TMP_AXIS_W-1:0]         req_axis;
   logic signed [TMP_CNT_W-1:0]   req_target_position;
   logic signed [TMP_SPEED_W-1:0] req_speed;
   logic [TMP_RATE_W-1:0]         req_accel;
   logic                          req_absolute;
   logic signed [TMP_CNT_W-1:0]   req_measured_position;
   logic                          req_servo_idle;
   logic                          rsp_strobe;
   logic [TMP_AXIS_W-1:0]         rsp_out_axis;
   logic signed [TMP_CNT_W-1:0]   rsp_set_position;
   logic                          rsp_active;
   logic                          rsp_last;

   profile_scoreboard sb = new();
   int quiet;
   bit burst;

   trapezoid_motion_profile dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_op                (req_op),
      .req_axis              (req_axis),
      .req_target_position   (req_target_position),
      .req_speed             (req_speed),
      .req_accel             (req_accel),
      .req_absolute          (req_absolute),
      .req_measured_position (req_measured_position),
      .req_servo_idle        (req_servo_idle),
      .rsp_strobe            (rsp_strobe),
      .rsp_out_axis          (rsp_out_axis),
      .rsp_set_position      (rsp_set_position),
      .rsp_active            (rsp_active),
      .rsp_last              (rsp_last)
   );

   always #2 clock = ~clock;

   // monitor: requests and set-points both land at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         quiet <= 0;
      end else begin
         if (start && !busy)
            sb.note('{req_op, req_axis, req_target_position, req_speed, req_accel,
                      req_absolute, req_measured_position, req_servo_idle});
         if (rsp_strobe)
            sb.check('{rsp_out_axis, rsp_set_position, rsp_active, rsp_last});
         if ((start && !busy) || rsp_strobe)
            quiet <= 0;
         else
            quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("trapezoid_motion_profile regression: fail");
            $finish;
         end
      end
   end

   function automatic motion_cmd_t cmd(logic [TMP_OP_W-1:0] op, int axis, int target,
                                       int speed, int accel, bit absolute, int meas,
                                       bit servo_idle);
      motion_cmd_t c;
      c.op         = op;
      c.axis       = TMP_AXIS_W'(axis);
      c.target     = target;
      c.speed      = TMP_SPEED_W'(speed);
      c.accel      = TMP_RATE_W'(accel);
      c.absolute   = absolute;
      c.measured   = meas;
      c.servo_idle = servo_idle;
      return c;
   endfunction

   function automatic motion_cmd_t random_cmd();
      motion_cmd_t c;
      int pick;
      int offset;
      pick = $urandom_range(0, 99);
      if (pick < 75)
         c.op = TMP_OP_TICK;
      else if (pick < 87)
         c.op = TMP_OP_MOVE;
      else if (pick < 95)
         c.op = TMP_OP_VELOCITY;
      else
         c.op = TMP_OP_STOP;
      c.axis       = TMP_AXIS_W'($urandom_range(0, AXES - 1));
      c.absolute   = $urandom_range(0, 1);
      c.servo_idle = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
         // noise: full-range fields
         c.target   = $urandom;
         c.speed    = TMP_SPEED_W'($urandom);
         c.accel    = TMP_RATE_W'($urandom);
         c.measured = $urandom;
      end else begin
         // short moves so that most of them reach their end position
         offset     = int'($urandom_range(0, 800)) - 400;
         c.measured = int'($urandom_range(0, 200000)) - 100000;
         c.target   = c.absolute ? c.measured + offset : offset;
         c.speed    = TMP_SPEED_W'($urandom_range(4, 48));
         if ($urandom_range(0, 1))
            c.speed = -c.speed;
         if (c.op == TMP_OP_VELOCITY && $urandom_range(0, 2) == 0)
            c.speed = '0;
         c.accel = TMP_RATE_W'($urandom_range(64, 1024));
      end
      return c;
   endfunction

   task automatic send(motion_cmd_t c);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                 <= 1'b1;
      req_op                <= c.op;
      req_axis              <= c.axis;
      req_target_position   <= c.target;
      req_speed             <= c.speed;
      req_accel             <= c.accel;
      req_absolute          <= c.absolute;
      req_measured_position <= c.measured;
      req_servo_idle        <= c.servo_idle;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      motion_cmd_t directed_q[$];
      clock                 = 1'b0;
      reset                 = 1'b1;
      start                 = 1'b0;
      req_op                = TMP_OP_TICK;
      req_axis              = '0;
      req_target_position   = '0;
      req_speed             = '0;
      req_accel             = '0;
      req_absolute          = 1'b0;
      req_measured_position = '0;
      req_servo_idle        = 1'b0;
      burst                 = 1'b0;

      directed_q.push_back(cmd(TMP_OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(cmd(TMP_OP_MOVE, 0, 40, 8, 512, 1, 0, 1));
      // busy axis and unsettled servo: both moves are dropped
      directed_q.push_back(cmd(TMP_OP_MOVE, 0, 32'h8000_0000, 5, 100, 1, 7, 1));
      directed_q.push_back(cmd(TMP_OP_MOVE, 1, -30, -6, 384, 0, 1000, 0));
      directed_q.push_back(cmd(TMP_OP_MOVE, 1, -30, -6, 384, 0, 1000, 1));
      directed_q.push_back(cmd(TMP_OP_VELOCITY, 2, 0, 24'h7F_FFFF, 16'hFFFF, 0,
                               32'h8000_0000, 1));
      directed_q.push_back(cmd(TMP_OP_VELOCITY, 3, 32'h7FFF_FFFF, 24'h80_0000, 0, 1,
                               32'h7FFF_FFFF, 0));
      repeat (10) directed_q.push_back(cmd(TMP_OP_TICK, 3, -1, -1, 16'hFFFF, 1, -1, 1));
      directed_q.push_back(cmd(TMP_OP_STOP, 2, 0, 0, 0, 0, 0, 0));
      // velocity stop: ramp the moving axis down to zero speed
      directed_q.push_back(cmd(TMP_OP_VELOCITY, 1, 0, 0, 256, 0, 0, 0));
      repeat (4) directed_q.push_back(cmd(TMP_OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(cmd(TMP_OP_MOVE, 3, 32'h7FFF_FFFF, 0, 16'hFFFF, 1,
                               32'h8000_0000, 1));
      directed_q.push_back(cmd(TMP_OP_TICK, 0, 0, 0, 0, 0, 0, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i])
         send(directed_q[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // every third stretch of 32 requests runs back to back
         burst = ((n / 32) % 3 == 2);
         send(random_cmd());
      end
      start <= 1'b0;

      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("trapezoid_motion_profile regression: pass");
      else
         $display("trapezoid_motion_profile regression: fail");
      $finish;
   end

endmodule
